[src/mrt_pkg.sv]
package mrt_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = 4;
	localparam int ADDR_W = 38;
	localparam int END_W = 39;
	localparam int LEN_W = 39;
	localparam int OFF_W = 31;
	localparam int PROT_W = 3;
	localparam int STAT_W = 3;

	// request types
	localparam logic [1:0] REQ_MAP    = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_UNMAP  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_FILE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
	localparam logic [STAT_W-1:0] ST_PERM     = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FND  = 3'd5;
	localparam logic [STAT_W-1:0] ST_MIDDLE   = 3'd6;

	// config register indexes
	localparam logic [0:0] REG_BASE = 1'd0;
	localparam logic [0:0] REG_TOP  = 1'd1;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic scan_clr;    // start a slot sweep
		logic scan_step;   // examine one slot
		logic next_cand;   // advance candidate to best end found
		logic commit_map;  // write new region, emit
		logic unmap_do;    // apply unmap, emit
		logic emit_err;    // emit an error status
		logic [STAT_W-1:0] err_code;
		logic emit_find;   // lookup hit / middle unmap
	} mrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req_type;
		logic file_ok;
		logic perm_ok;
		logic scan_last;   // slot index at last entry
		logic cand_bad;    // candidate out of range
		logic overlap;     // candidate overlaps some region
		logic have_next;   // some region ends beyond candidate
		logic free_found;
		logic hit;         // address found
		logic middle;      // unmap would punch a hole
	} mrt_stat_t;

endpackage

[src/mapped_region_table.sv]
// Channel   Handshake           Payload
// request   start / busy        req_type address span_length protection shared_map file_*
// result    done (one cycle)    status slot mapped_address region_* write_back
// config    APB psel/penable    base_address (0x0), top_address (0x8)
//
// A request is taken when start is high and busy low. For lookup and unmap the
// result strobe rises after one 16-slot sweep, and busy drops with it; a map
// sweeps the slots once per gap candidate, up to 17 candidates, bounded by the
// serial slot scan. A bad file or an unknown request answers from the dispatch
// state without a sweep. Reset clears the table and control at once. The result
// strobe done lasts one cycle; the receiver cannot stall.
module mapped_region_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [37:0] address,
	input  logic [38:0] span_length,
	input  logic [2:0]  protection,
	input  logic        shared_map,
	input  logic        file_mappable,
	input  logic        file_readable,
	input  logic        file_writable,
	input  logic [30:0] file_offset,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [37:0] mapped_address,
	output logic [37:0] region_start,
	output logic [38:0] region_end,
	output logic [2:0]  region_protection,
	output logic        region_shared,
	output logic [30:0] region_offset,
	output logic        write_back,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import mrt_pkg::*;

	logic [37:0] base_q;
	logic [38:0] top_q;
	mrt_cmd_t    cmd;
	mrt_stat_t   st;
	logic        wr_en;

	// config registers
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 38'h10_0000_0000;
			top_q <= 39'h40_0000_0000;
		end else if (wr_en && paddr[2:0] == 3'd0 && paddr[3] == REG_BASE) begin
			base_q <= pwdata[37:0];
		end else if (wr_en && paddr[2:0] == 3'd0 && paddr[3] == REG_TOP) begin
			top_q <= pwdata[38:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0 && paddr[3] == REG_BASE) prdata = {26'd0, base_q};
		else if (paddr[2:0] == 3'd0 && paddr[3] == REG_TOP) prdata = {25'd0, top_q};
	end

	mrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
	);

	mrt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .base_q(base_q), .top_q(top_q),
		.req_type(req_type), .address(address), .span_length(span_length),
		.protection(protection), .shared_map(shared_map), .file_mappable(file_mappable),
		.file_readable(file_readable), .file_writable(file_writable),
		.file_offset(file_offset), .done(done), .status(status), .slot(slot),
		.mapped_address(mapped_address), .region_start(region_start),
		.region_end(region_end), .region_protection(region_protection),
		.region_shared(region_shared), .region_offset(region_offset),
		.write_back(write_back)
	);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without request");
	a_wb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_back) |-> status == ST_OK) else $error("write-back on failure");
	a_map_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mapped_address != '0) |-> mapped_address == region_start)
		else $error("mapped address mismatch");
`endif

endmodule

[src/mrt_ctrl.sv]
module mrt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mrt_pkg::mrt_stat_t st,
	output mrt_pkg::mrt_cmd_t  cmd
);
	import mrt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_GAP   = 3'd2;
	localparam logic [2:0] S_GAPCK = 3'd3;
	localparam logic [2:0] S_FIND  = 3'd4;
	localparam logic [2:0] S_FINDK = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [SLOT_W+1:0] iter_q;
	logic [SLOT_W+1:0] iter_d;

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		iter_d = iter_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.scan_clr = 1'b1;
				iter_d = '0;
				priority if (st.req_type == REQ_MAP && !st.file_ok) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = ST_BAD_FILE;
					state_d = S_IDLE;
				end else if (st.req_type == REQ_MAP) begin
					state_d = S_GAP;
				end else if (st.req_type == REQ_LOOKUP || st.req_type == REQ_UNMAP) begin
					state_d = S_FIND;
				end else begin
					cmd.emit_err = 1'b1;
					cmd.err_code = ST_NOT_FND;
					state_d = S_IDLE;
				end
			end
			S_GAP: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) state_d = S_GAPCK;
			end
			S_GAPCK: begin
				priority if (st.cand_bad) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = ST_NO_SPACE;
					state_d = S_IDLE;
				end else if (!st.overlap) begin
					priority if (!st.perm_ok) begin
						cmd.emit_err = 1'b1;
						cmd.err_code = ST_PERM;
					end else if (!st.free_found) begin
						cmd.emit_err = 1'b1;
						cmd.err_code = ST_FULL;
					end else begin
						cmd.commit_map = 1'b1;
					end
					state_d = S_IDLE;
				end else if (!st.have_next || iter_q == (SLOT_W+2)'(SLOTS)) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = ST_NO_SPACE;
					state_d = S_IDLE;
				end else begin
					cmd.next_cand = 1'b1;
					cmd.scan_clr = 1'b1;
					iter_d = iter_q + 1'b1;
					state_d = S_GAP;
				end
			end
			S_FIND: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) state_d = S_FINDK;
			end
			S_FINDK: begin
				priority if (!st.hit) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = ST_NOT_FND;
				end else if (st.req_type == REQ_LOOKUP) begin
					cmd.emit_find = 1'b1;
				end else if (st.middle) begin
					cmd.emit_find = 1'b1;
					cmd.err_code = ST_MIDDLE;
				end else begin
					cmd.unmap_do = 1'b1;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
		end else begin
			state_q <= state_d;
			iter_q <= iter_d;
		end
	end

endmodule

[src/mrt_dp.sv]
module mrt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrt_pkg::mrt_cmd_t            cmd,
	output mrt_pkg::mrt_stat_t           st,
	input  logic [37:0]                  base_q,
	input  logic [38:0]                  top_q,
	input  logic [1:0]                   req_type,
	input  logic [37:0]                  address,
	input  logic [38:0]                  span_length,
	input  logic [2:0]                   protection,
	input  logic                         shared_map,
	input  logic                         file_mappable,
	input  logic                         file_readable,
	input  logic                         file_writable,
	input  logic [30:0]                  file_offset,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [3:0]                   slot,
	output logic [37:0]                  mapped_address,
	output logic [37:0]                  region_start,
	output logic [38:0]                  region_end,
	output logic [2:0]                   region_protection,
	output logic                         region_shared,
	output logic [30:0]                  region_offset,
	output logic                         write_back
);
	import mrt_pkg::*;

	localparam logic [END_W:0] LIM = (END_W+1)'(1) << ADDR_W;

	// region table
	logic              valid_q [SLOTS];
	logic [ADDR_W-1:0] start_q [SLOTS];
	logic [END_W-1:0]  end_q   [SLOTS];
	logic [PROT_W-1:0] prot_q  [SLOTS];
	logic              shr_q   [SLOTS];
	logic [OFF_W-1:0]  off_q   [SLOTS];

	// captured request
	logic [1:0]        type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [PROT_W-1:0] rprot_q;
	logic              rshr_q, fmap_q, frd_q, fwr_q;
	logic [OFF_W-1:0]  roff_q;

	// scan state
	logic [SLOT_W-1:0] idx_q;
	logic [END_W-1:0]  cand_q;
	logic              ovl_q, have_q, hit_q, free_q;
	logic [END_W-1:0]  best_q;
	logic [SLOT_W-1:0] hslot_q, fslot_q;

	// output registers
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] maddr_q, rstart_q;
	logic [END_W-1:0]  rend_q;
	logic [PROT_W-1:0] oprot_q;
	logic              oshr_q, wb_q;
	logic [OFF_W-1:0]  ooff_q;

	// next result fields
	logic [STAT_W-1:0] status_d;
	logic [SLOT_W-1:0] slot_d;
	logic [ADDR_W-1:0] maddr_d, rstart_d;
	logic [END_W-1:0]  rend_d;
	logic [PROT_W-1:0] oprot_d;
	logic              oshr_d, wb_d;
	logic [OFF_W-1:0]  ooff_d;

	// per-slot tests on the slot under scan
	logic [END_W:0]    cand_hi;
	logic [END_W:0]    top_lim;
	logic [END_W-1:0]  e_start;
	logic              e_ovl, e_next, e_hit;
	logic [END_W:0]    stop;
	logic              is_start, is_end;

	assign cand_hi = {1'b0, cand_q} + {1'b0, len_q};
	assign top_lim = ({1'b0, top_q} < LIM) ? {1'b0, top_q} : LIM;
	assign e_start = {1'b0, start_q[idx_q]};
	// empty regions overlap nothing
	assign e_ovl = valid_q[idx_q] && (cand_hi > {1'b0, e_start})
		&& (cand_q < end_q[idx_q]) && (cand_hi > {1'b0, cand_q})
		&& (e_start < end_q[idx_q]);
	assign e_next = valid_q[idx_q] && (end_q[idx_q] > cand_q);
	assign e_hit = valid_q[idx_q] && (start_q[idx_q] <= addr_q)
		&& ({1'b0, addr_q} < end_q[idx_q]);

	assign stop = {2'b0, addr_q} + {1'b0, len_q};
	assign is_start = (addr_q == start_q[hslot_q]);
	assign is_end = (stop == {1'b0, end_q[hslot_q]});

	always_comb begin
		st.req_type = type_q;
		st.file_ok = fmap_q;
		st.perm_ok = !((rprot_q[0] && !frd_q) || (rprot_q[1] && rshr_q && !fwr_q));
		st.scan_last = (idx_q == SLOT_W'(SLOTS-1));
		st.cand_bad = ({1'b0, cand_q} >= LIM) || (cand_hi > top_lim);
		st.overlap = ovl_q;
		st.have_next = have_q;
		st.free_found = free_q;
		st.hit = hit_q;
		st.middle = !is_start && !is_end;
	end

	// request capture and scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			addr_q <= address;
			len_q <= span_length;
			rprot_q <= protection;
			rshr_q <= shared_map;
			fmap_q <= file_mappable;
			frd_q <= file_readable;
			fwr_q <= file_writable;
			roff_q <= file_offset;
			cand_q <= {1'b0, base_q};
		end
		if (cmd.next_cand) cand_q <= best_q;
		if (cmd.scan_clr) begin
			idx_q <= '0;
			ovl_q <= 1'b0;
			have_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			best_q <= '0;
		end
		if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (e_ovl) ovl_q <= 1'b1;
			if (e_next && (!have_q || end_q[idx_q] < best_q)) begin
				have_q <= 1'b1;
				best_q <= end_q[idx_q];
			end
			if (e_hit && !hit_q) begin
				hit_q <= 1'b1;
				hslot_q <= idx_q;
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_q <= 1'b1;
				fslot_q <= idx_q;
			end
		end
	end

	// table writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				start_q[i] <= '0;
				end_q[i] <= '0;
				prot_q[i] <= '0;
				shr_q[i] <= 1'b0;
				off_q[i] <= '0;
			end
		end else if (cmd.commit_map) begin
			valid_q[fslot_q] <= 1'b1;
			start_q[fslot_q] <= cand_q[ADDR_W-1:0];
			end_q[fslot_q] <= cand_hi[END_W-1:0];
			prot_q[fslot_q] <= rprot_q;
			shr_q[fslot_q] <= rshr_q;
			off_q[fslot_q] <= roff_q;
		end else if (cmd.unmap_do) begin
			priority if (is_start && stop >= {1'b0, end_q[hslot_q]}) begin
				valid_q[hslot_q] <= 1'b0;
			end else if (is_start) begin
				start_q[hslot_q] <= stop[ADDR_W-1:0];
			end else begin
				end_q[hslot_q] <= {1'b0, addr_q};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_err || cmd.commit_map || cmd.unmap_do || cmd.emit_find;
		end
	end

	// result fields; on an error everything but status is zero, but a middle unmap reports its region
	always_comb begin
		status_d = ST_OK;
		slot_d = '0;
		maddr_d = '0;
		rstart_d = '0;
		rend_d = '0;
		oprot_d = '0;
		oshr_d = 1'b0;
		ooff_d = '0;
		wb_d = 1'b0;
		priority if (cmd.emit_err) begin
			status_d = cmd.err_code;
		end else if (cmd.commit_map) begin
			slot_d = fslot_q;
			maddr_d = cand_q[ADDR_W-1:0];
			rstart_d = cand_q[ADDR_W-1:0];
			rend_d = cand_hi[END_W-1:0];
			oprot_d = rprot_q;
			oshr_d = rshr_q;
			ooff_d = roff_q;
		end else if (cmd.emit_find || cmd.unmap_do) begin
			status_d = cmd.emit_find ? cmd.err_code : ST_OK;
			slot_d = hslot_q;
			rstart_d = start_q[hslot_q];
			rend_d = end_q[hslot_q];
			oprot_d = prot_q[hslot_q];
			oshr_d = shr_q[hslot_q];
			ooff_d = off_q[hslot_q];
			if (cmd.unmap_do) begin
				wb_d = shr_q[hslot_q];
				if (is_start && stop < {1'b0, end_q[hslot_q]})
					rstart_d = stop[ADDR_W-1:0];
				else if (!is_start)
					rend_d = {1'b0, addr_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		slot_q <= slot_d;
		maddr_q <= maddr_d;
		rstart_q <= rstart_d;
		rend_q <= rend_d;
		oprot_q <= oprot_d;
		oshr_q <= oshr_d;
		ooff_q <= ooff_d;
		wb_q <= wb_d;
	end

	assign done = done_q;
	assign status = status_q;
	assign slot = slot_q;
	assign mapped_address = maddr_q;
	assign region_start = rstart_q;
	assign region_end = rend_q;
	assign region_protection = oprot_q;
	assign region_shared = oshr_q;
	assign region_offset = ooff_q;
	assign write_back = wb_q;

endmodule
